>>> design/slhd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slhd_pkg;

	// storage and field widths
	localparam int NUM_CPUS_DEFAULT = 8;
	localparam int CPU_W            = 3;
	localparam int MODE_W           = 3;
	localparam int NOW_W            = 64;
	localparam int SEC_SHIFT        = 30;
	localparam int SEC_W            = 34;
	localparam int TICK_W           = 32;
	localparam int THR_W            = 12;
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 4;

	// register reset values
	localparam logic             WATCHDOG_ON_RST    = 1'b1;
	localparam logic [THR_W-1:0] SOFT_THRESHOLD_RST = 12'd60;
	localparam logic             SOFT_PANIC_RST     = 1'b0;
	localparam logic             HARD_PANIC_RST     = 1'b0;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK         = 3'd0,
		MODE_THREAD_TOUCH = 3'd1,
		MODE_TOUCH_SOFT   = 3'd2,
		MODE_TOUCH_SYNC   = 3'd3,
		MODE_TOUCH_NMI    = 3'd4,
		MODE_TOUCH_ALL    = 3'd5,
		MODE_NMI_OVERFLOW = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		REG_WATCHDOG_ON    = 2'd0,
		REG_SOFT_THRESHOLD = 2'd1,
		REG_SOFT_PANIC     = 2'd2,
		REG_HARD_PANIC     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             watchdog_on;
		logic [THR_W-1:0] soft_threshold;
		logic             soft_panic;
		logic             hard_panic;
	} cfg_t;

	typedef struct packed {
		logic             soft_lockup;
		logic [SEC_W-1:0] stuck_seconds;
		logic             hard_lockup;
		logic             panic_request;
		logic             clock_tick_request;
	} res_t;

endpackage

`default_nettype wire

>>> design/slhd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module slhd_core #(
	parameter int NUM_CPUS = slhd_pkg::NUM_CPUS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire slhd_pkg::mode_t               mode,
	input  wire logic [slhd_pkg::CPU_W-1:0]    cpu,
	input  wire logic [slhd_pkg::SEC_W-1:0]    now_sec,
	input  wire slhd_pkg::cfg_t                cfg,
	output slhd_pkg::res_t                     res
);

	localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

	logic [slhd_pkg::SEC_W-1:0]  stamp_q   [NUM_CPUS];
	logic [slhd_pkg::TICK_W-1:0] tick_q    [NUM_CPUS];
	logic [slhd_pkg::TICK_W-1:0] seen_q    [NUM_CPUS];
	logic [NUM_CPUS-1:0]         sync_q;
	logic [NUM_CPUS-1:0]         nmi_sup_q;
	logic [NUM_CPUS-1:0]         soft_rep_q;
	logic [NUM_CPUS-1:0]         hard_rep_q;

	logic                        in_range;
	logic [IDX_W-1:0]            idx;
	logic [slhd_pkg::SEC_W-1:0]  stamp_cur;
	logic [slhd_pkg::TICK_W-1:0] tick_cur;
	logic [slhd_pkg::TICK_W-1:0] seen_cur;
	logic [slhd_pkg::SEC_W-1:0]  limit;
	logic [slhd_pkg::SEC_W-1:0]  diff;
	logic [slhd_pkg::SEC_W-1:0]  stuck;
	logic                        stamp_zero;
	logic                        overdue;

	assign in_range   = (int'(cpu) < NUM_CPUS);
	assign idx        = IDX_W'(cpu);
	assign stamp_cur  = stamp_q[idx];
	assign tick_cur   = tick_q[idx];
	assign seen_cur   = seen_q[idx];
	assign stamp_zero = (stamp_cur == '0);

	// wrap-aware age check: limit - now negative means past the threshold
	assign limit   = stamp_cur + slhd_pkg::SEC_W'(cfg.soft_threshold);
	assign diff    = limit - now_sec;
	assign overdue = diff[slhd_pkg::SEC_W-1];
	assign stuck   = now_sec - stamp_cur;

	always_comb begin
		res = '0;
		if (in_range) begin
			case (mode)
				slhd_pkg::MODE_TICK: begin
					if (stamp_zero) begin
						res.clock_tick_request = sync_q[idx];
					end else if (overdue && !soft_rep_q[idx]) begin
						res.soft_lockup   = 1'b1;
						res.stuck_seconds = stuck;
						res.panic_request = cfg.soft_panic;
					end
				end
				slhd_pkg::MODE_NMI_OVERFLOW: begin
					if (!nmi_sup_q[idx] && (seen_cur == tick_cur) && !hard_rep_q[idx]) begin
						res.hard_lockup   = 1'b1;
						res.panic_request = cfg.hard_panic;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				stamp_q[i] <= '0;
				tick_q[i]  <= '0;
				seen_q[i]  <= '0;
			end
			sync_q     <= '0;
			nmi_sup_q  <= '0;
			soft_rep_q <= '0;
			hard_rep_q <= '0;
		end else if (fire && in_range) begin
			case (mode)
				slhd_pkg::MODE_TICK: begin
					tick_q[idx] <= tick_cur + 32'd1;
					if (stamp_zero) begin
						sync_q[idx]  <= 1'b0;
						stamp_q[idx] <= now_sec;
					end else if (overdue) begin
						soft_rep_q[idx] <= 1'b1;
					end else begin
						soft_rep_q[idx] <= 1'b0;
					end
				end
				slhd_pkg::MODE_THREAD_TOUCH: begin
					stamp_q[idx] <= now_sec;
				end
				slhd_pkg::MODE_TOUCH_SOFT: begin
					stamp_q[idx] <= '0;
				end
				slhd_pkg::MODE_TOUCH_SYNC: begin
					sync_q[idx]  <= 1'b1;
					stamp_q[idx] <= '0;
				end
				slhd_pkg::MODE_TOUCH_NMI: begin
					if (cfg.watchdog_on) begin
						nmi_sup_q <= '1;
					end
					stamp_q[idx] <= '0;
				end
				slhd_pkg::MODE_TOUCH_ALL: begin
					for (int i = 0; i < NUM_CPUS; i++) begin
						stamp_q[i] <= '0;
					end
				end
				slhd_pkg::MODE_NMI_OVERFLOW: begin
					// a touch skips exactly one check
					if (nmi_sup_q[idx]) begin
						nmi_sup_q[idx] <= 1'b0;
					end else if (seen_cur == tick_cur) begin
						hard_rep_q[idx] <= 1'b1;
					end else begin
						seen_q[idx]     <= tick_cur;
						hard_rep_q[idx] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/soft_hard_lockup_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// per-cpu soft and hard lockup watchdog
// input channel (in_valid / in_stall) carries one event transaction: mode, cpu and
// the free-running clock now_ns; seconds are now_ns >> 30 (34 bits)
// output channel (out_valid / out_stall) returns exactly one result transaction per
// event: soft_lockup with stuck_seconds, hard_lockup, panic_request and
// clock_tick_request; quiet events return all zeros
// path: an accepted event is held in the input register, then its result is
// captured in the result register, which drives out_valid
// throughput: one event per cycle while the result side is not stalled; the
// per-cpu read-modify-write of the stamp, tick counter and flags is plain
// 34-bit add and subtract logic between the input register and the result
// register; state updates land at the same edge as the result, so the next event already sees them
// stall: while the result register is full and out_stall is high, the event in
// the input register waits and in_stall rises; nothing is dropped or repeated
// reset: arst_n clears all per-cpu state, empties both registers and restores
// the config registers (watchdog_on 1, soft_threshold 60, panics off)
// config: apb port, register i at byte address 4*i, pready always high; write
// only while no event is in flight
module soft_hard_lockup_detector #(
	parameter int NUM_CPUS = slhd_pkg::NUM_CPUS_DEFAULT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// event channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [slhd_pkg::MODE_W-1:0]           mode,
	input  wire logic [slhd_pkg::CPU_W-1:0]            cpu,
	input  wire logic [slhd_pkg::NOW_W-1:0]            now_ns,
	// result channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       soft_lockup,
	output logic [slhd_pkg::SEC_W-1:0]                 stuck_seconds,
	output logic                                       hard_lockup,
	output logic                                       panic_request,
	output logic                                       clock_tick_request,
	// apb config port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [slhd_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire logic [slhd_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [slhd_pkg::APB_DATA_W-1:0]            prdata,
	output logic                                       pready
);

	// config registers
	slhd_pkg::cfg_t             cfg_q;
	slhd_pkg::reg_idx_t         reg_sel;
	logic                       cfg_wr;

	// input register
	logic                       valid_s1;
	slhd_pkg::mode_t            mode_s1;
	logic [slhd_pkg::CPU_W-1:0] cpu_s1;
	logic [slhd_pkg::SEC_W-1:0] now_sec_s1;

	// result register
	logic                       out_valid_q;
	slhd_pkg::res_t             res_q;
	slhd_pkg::res_t             res_next;

	logic                       advance;
	logic                       fire;

	// ---------------------------------------------------------------------------
	// apb: writes complete in the access phase, reads are plain muxes
	// ---------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = slhd_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watchdog_on    <= slhd_pkg::WATCHDOG_ON_RST;
			cfg_q.soft_threshold <= slhd_pkg::SOFT_THRESHOLD_RST;
			cfg_q.soft_panic     <= slhd_pkg::SOFT_PANIC_RST;
			cfg_q.hard_panic     <= slhd_pkg::HARD_PANIC_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				slhd_pkg::REG_WATCHDOG_ON:    cfg_q.watchdog_on    <= pwdata[0];
				slhd_pkg::REG_SOFT_THRESHOLD: cfg_q.soft_threshold <= pwdata[slhd_pkg::THR_W-1:0];
				slhd_pkg::REG_SOFT_PANIC:     cfg_q.soft_panic     <= pwdata[0];
				slhd_pkg::REG_HARD_PANIC:     cfg_q.hard_panic     <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			slhd_pkg::REG_WATCHDOG_ON:    prdata = slhd_pkg::APB_DATA_W'(cfg_q.watchdog_on);
			slhd_pkg::REG_SOFT_THRESHOLD: prdata = slhd_pkg::APB_DATA_W'(cfg_q.soft_threshold);
			slhd_pkg::REG_SOFT_PANIC:     prdata = slhd_pkg::APB_DATA_W'(cfg_q.soft_panic);
			slhd_pkg::REG_HARD_PANIC:     prdata = slhd_pkg::APB_DATA_W'(cfg_q.hard_panic);
			default:                      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------------
	// handshake: the input register moves on whenever the result register is
	// empty or being taken this cycle
	// ---------------------------------------------------------------------------
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// event payload; only the seconds part of the clock is kept
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1    <= slhd_pkg::mode_t'(mode);
			cpu_s1     <= cpu;
			now_sec_s1 <= now_ns[slhd_pkg::SEC_SHIFT +: slhd_pkg::SEC_W];
		end
	end

	// per-cpu state and the single-pass decision logic
	slhd_core #(
		.NUM_CPUS (NUM_CPUS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.mode    (mode_s1),
		.cpu     (cpu_s1),
		.now_sec (now_sec_s1),
		.cfg     (cfg_q),
		.res     (res_next)
	);

	// ---------------------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign out_valid          = out_valid_q;
	assign soft_lockup        = res_q.soft_lockup;
	assign stuck_seconds      = res_q.stuck_seconds;
	assign hard_lockup        = res_q.hard_lockup;
	assign panic_request      = res_q.panic_request;
	assign clock_tick_request = res_q.clock_tick_request;

endmodule

`default_nettype wire

>>> design/slhd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slhd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        soft_lockup,
	input wire logic [slhd_pkg::SEC_W-1:0]  stuck_seconds,
	input wire logic                        hard_lockup,
	input wire logic                        panic_request,
	input wire logic                        clock_tick_request
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(soft_lockup)
			&& $stable(stuck_seconds) && $stable(hard_lockup)
			&& $stable(panic_request) && $stable(clock_tick_request))
		else $error("result changed while stalled");

	// input side only backs up when the result side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// a duration is reported with a soft lockup and only then, never zero
	a_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (soft_lockup == (stuck_seconds != '0)))
		else $error("stuck_seconds does not match soft_lockup");

	// panic only rides on a report, and one event gives at most one kind of report
	a_panic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && panic_request |-> soft_lockup || hard_lockup)
		else $error("panic request without a report");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({soft_lockup, hard_lockup, clock_tick_request}) <= 1)
		else $error("more than one kind of result in one transaction");

endmodule

bind soft_hard_lockup_detector slhd_checker u_slhd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_stall           (in_stall),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.soft_lockup        (soft_lockup),
	.stuck_seconds      (stuck_seconds),
	.hard_lockup        (hard_lockup),
	.panic_request      (panic_request),
	.clock_tick_request (clock_tick_request)
);

`default_nettype wire

>>> tb/lockup_check_pkg.sv
`timescale 1ns / 1ps

package lockup_check_pkg;
	import slhd_pkg::*;

	localparam int NCPU = NUM_CPUS_DEFAULT;

	class lockup_scoreboard;
		bit              wd_on;
		bit [THR_W-1:0]  threshold;
		bit              soft_pan;
		bit              hard_pan;
		bit [SEC_W-1:0]  stamp [NCPU];
		bit [TICK_W-1:0] ticks [NCPU];
		bit [TICK_W-1:0] ticks_seen [NCPU];
		bit              sync_pend [NCPU];
		bit              nmi_supp [NCPU];
		bit              soft_done [NCPU];
		bit              hard_done [NCPU];
		res_t            expected_reports [$];
		int unsigned     faults;

		function new();
			wd_on     = WATCHDOG_ON_RST;
			threshold = SOFT_THRESHOLD_RST;
			soft_pan  = SOFT_PANIC_RST;
			hard_pan  = HARD_PANIC_RST;
			faults    = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
			case (idx)
				REG_WATCHDOG_ON: wd_on = value[0];
				REG_SOFT_THRESHOLD: threshold = value[THR_W-1:0];
				REG_SOFT_PANIC: soft_pan = value[0];
				REG_HARD_PANIC: hard_pan = value[0];
				default: ;
			endcase
		endfunction

		// works out the report of one accepted event and updates the per-cpu state
		function void note_event(logic [MODE_W-1:0] mode, logic [CPU_W-1:0] cpu,
				logic [NOW_W-1:0] now_ns);
			res_t           r;
			bit [SEC_W-1:0] now_s;
			bit [SEC_W-1:0] limit_s;
			bit [SEC_W-1:0] margin;
			r = '0;
			now_s = now_ns[SEC_SHIFT +: SEC_W];
			if (cpu < NCPU) begin
				case (mode)
					MODE_TICK: begin
						ticks[cpu] = ticks[cpu] + 1;
						if (stamp[cpu] == '0) begin
							if (sync_pend[cpu]) begin
								sync_pend[cpu] = 1'b0;
								r.clock_tick_request = 1'b1;
							end
							stamp[cpu] = now_s;
						end else begin
							limit_s = stamp[cpu] + SEC_W'(threshold);
							margin = limit_s - now_s;
							if (margin[SEC_W-1]) begin
								if (!soft_done[cpu]) begin
									r.soft_lockup   = 1'b1;
									r.stuck_seconds = now_s - stamp[cpu];
									r.panic_request = soft_pan;
									soft_done[cpu]  = 1'b1;
								end
							end else begin
								soft_done[cpu] = 1'b0;
							end
						end
					end
					MODE_THREAD_TOUCH: stamp[cpu] = now_s;
					MODE_TOUCH_SOFT: stamp[cpu] = '0;
					MODE_TOUCH_SYNC: begin
						sync_pend[cpu] = 1'b1;
						stamp[cpu] = '0;
					end
					MODE_TOUCH_NMI: begin
						if (wd_on)
							foreach (nmi_supp[i]) nmi_supp[i] = 1'b1;
						stamp[cpu] = '0;
					end
					MODE_TOUCH_ALL: foreach (stamp[i]) stamp[i] = '0;
					MODE_NMI_OVERFLOW: begin
						if (nmi_supp[cpu]) begin
							nmi_supp[cpu] = 1'b0;
						end else if (ticks_seen[cpu] == ticks[cpu]) begin
							if (!hard_done[cpu]) begin
								r.hard_lockup   = 1'b1;
								r.panic_request = hard_pan;
								hard_done[cpu]  = 1'b1;
							end
						end else begin
							ticks_seen[cpu] = ticks[cpu];
							hard_done[cpu] = 1'b0;
						end
					end
					default: ;
				endcase
			end
			expected_reports.push_back(r);
		endfunction

		function void check_report(res_t got);
			res_t want;
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, got %h",
					$time, got);
				faults++;
				return;
			end
			want = expected_reports.pop_front();
			if (got.soft_lockup !== want.soft_lockup) begin
				$display("%0t: soft_lockup expected %0d got %0d", $time,
					want.soft_lockup, got.soft_lockup);
				faults++;
			end
			if (got.stuck_seconds !== want.stuck_seconds) begin
				$display("%0t: stuck_seconds expected %0d got %0d", $time,
					want.stuck_seconds, got.stuck_seconds);
				faults++;
			end
			if (got.hard_lockup !== want.hard_lockup) begin
				$display("%0t: hard_lockup expected %0d got %0d", $time,
					want.hard_lockup, got.hard_lockup);
				faults++;
			end
			if (got.panic_request !== want.panic_request) begin
				$display("%0t: panic_request expected %0d got %0d", $time,
					want.panic_request, got.panic_request);
				faults++;
			end
			if (got.clock_tick_request !== want.clock_tick_request) begin
				$display("%0t: clock_tick_request expected %0d got %0d", $time,
					want.clock_tick_request, got.clock_tick_request);
				faults++;
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import slhd_pkg::*;
	import lockup_check_pkg::*;

	// cycles with no transaction on either channel and no apb access before the run is abandoned
	localparam int STALL_LIMIT = 5000;
	localparam int NUM_PHASES  = 6;
	localparam int PHASE_ITEMS = 275;
	localparam int HOLD_CYCLES = 80;

	// mode code outside the defined set, the block must ignore it
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	// register settings per phase; the last phase draws its threshold at random
	localparam bit             PH_ON  [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
	localparam bit [THR_W-1:0] PH_THR [NUM_PHASES] =
		'{12'd60, 12'd1, 12'd3600, 12'd0, 12'd4095, 12'd60};
	localparam bit             PH_SP  [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
	localparam bit             PH_HP  [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [MODE_W-1:0]     mode      = '0;
	logic [CPU_W-1:0]      cpu       = '0;
	logic [NOW_W-1:0]      now_ns    = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  soft_lockup;
	logic [SEC_W-1:0]      stuck_seconds;
	logic                  hard_lockup;
	logic                  panic_request;
	logic                  clock_tick_request;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lockup_scoreboard sb;

	// idle percentages of the two sides, set per phase by the stimulus
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// one-shot request for a long receiver hold-off, consumed by the receiver
	bit hold_request  = 1'b0;
	int hold_left     = 0;
	int idle_cycles   = 0;

	soft_hard_lockup_detector #(
		.NUM_CPUS(NUM_CPUS_DEFAULT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.cpu(cpu),
		.now_ns(now_ns),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.soft_lockup(soft_lockup),
		.stuck_seconds(stuck_seconds),
		.hard_lockup(hard_lockup),
		.panic_request(panic_request),
		.clock_tick_request(clock_tick_request),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// receiver: random stall per cycle, or a long hold-off so the block backs up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// result monitor and progress counter, sampled at the rising edge
	always @(posedge clk) begin : monitor
		res_t got;
		bit   moved;
		if (arst_n) begin
			moved = psel || (in_valid && !in_stall);
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = {soft_lockup, stuck_seconds, hard_lockup, panic_request,
					clock_tick_request};
				sb.check_report(got);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// watchdog: nothing moved for too long
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("tb: errors");
		$finish;
	end

	// offers one event transaction; entered and left at a falling edge, valid stays
	// high on return so back-to-back transactions never toggle it within a step
	task automatic send_event(logic [MODE_W-1:0] m, logic [CPU_W-1:0] c,
			logic [NOW_W-1:0] t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		cpu      <= c;
		now_ns   <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_event(m, c, t);
		@(negedge clk);
	endtask

	// apb write: setup phase, access phase, then psel drops and the bus idles
	task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// lowers valid and waits until every expected result transaction is back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// then idle on before touching the registers
		repeat (3) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [SEC_W-1:0]  sec_base;
		logic [MODE_W-1:0] m;
		logic [CPU_W-1:0]  c;
		logic [NOW_W-1:0]  t;
		logic [THR_W-1:0]  thr;
		int                pick;

		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under reset settings: sender sparse idle, receiver heavy
		send_idle_pct = 8;
		recv_idle_pct = 88;
		// clock at zero seconds re-arms to zero, so the next tick re-arms again
		send_event(MODE_TICK, 3'd0, '0);
		send_event(MODE_TICK, 3'd0, {34'd0, 30'h3FFF_FFFF});
		// stamp at the top of the range, then a clock past the wrap: soft lockup
		send_event(MODE_TICK, 3'd1, '1);
		send_event(MODE_TICK, 3'd1, {34'd100, 30'd5});
		send_event(MODE_TICK, 3'd1, {34'd150, 30'd0});
		// thread touch, back under the threshold clears the episode, then a new one
		send_event(MODE_THREAD_TOUCH, 3'd1, {34'd200, 30'd0});
		send_event(MODE_TICK, 3'd1, {34'd201, 30'd0});
		send_event(MODE_TICK, 3'd1, {34'd261, 30'd0});
		// sync touch turns into a clock-tick request on the re-arming tick
		send_event(MODE_TOUCH_SYNC, 3'd2, {34'h2_AAAA_AAAA, 30'h1555_5555});
		send_event(MODE_TICK, 3'd2, {34'h1_5555_5555, 30'h2AAA_AAAA});
		send_event(MODE_TOUCH_SOFT, 3'd2, '1);
		send_event(MODE_TICK, 3'd2, {34'd7, 30'd0});
		// nmi with no tick since reset: hard lockup once, then a tick clears it
		send_event(MODE_NMI_OVERFLOW, 3'd3, '0);
		send_event(MODE_NMI_OVERFLOW, 3'd3, '0);
		send_event(MODE_TICK, 3'd3, {34'd9, 30'd0});
		send_event(MODE_NMI_OVERFLOW, 3'd3, {34'd9, 30'd1});
		// nmi touch broadcast suppresses exactly one check on every cpu
		send_event(MODE_TOUCH_NMI, 3'd4, {34'd10, 30'd0});
		send_event(MODE_NMI_OVERFLOW, 3'd4, '1);
		send_event(MODE_NMI_OVERFLOW, 3'd4, '1);
		send_event(MODE_NMI_OVERFLOW, 3'd5, '0);
		send_event(MODE_TOUCH_ALL, 3'd5, {34'd11, 30'd0});
		// unused mode code changes nothing
		send_event(MODE_UNUSED, 3'd6, '1);
		send_event(MODE_TICK, 3'd7, '1);
		send_event(MODE_TICK, 3'd7, '0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			thr = (p == NUM_PHASES - 1) ? THR_W'($urandom_range(1, 3600)) : PH_THR[p];
			write_reg(REG_WATCHDOG_ON, APB_DATA_W'(PH_ON[p]));
			write_reg(REG_SOFT_THRESHOLD, APB_DATA_W'(thr));
			write_reg(REG_SOFT_PANIC, APB_DATA_W'(PH_SP[p]));
			write_reg(REG_HARD_PANIC, APB_DATA_W'(PH_HP[p]));

			// idle regimes: sender sparse, then receiver sparse, then no idling
			if (p < 2) begin
				send_idle_pct = 8;
				recv_idle_pct = 88;
			end else if (p < 4) begin
				send_idle_pct = 88;
				recv_idle_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// each phase runs its own clock from a random point so high bits toggle
			sec_base = SEC_W'({$urandom, $urandom});
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver goes quiet while the sender keeps offering
				if (p == 4 && n == 100)
					hold_request = 1'b1;

				pick = $urandom_range(0, 99);
				if (pick < 38)
					m = MODE_TICK;
				else if (pick < 48)
					m = MODE_THREAD_TOUCH;
				else if (pick < 55)
					m = MODE_TOUCH_SOFT;
				else if (pick < 61)
					m = MODE_TOUCH_SYNC;
				else if (pick < 66)
					m = MODE_TOUCH_NMI;
				else if (pick < 69)
					m = MODE_TOUCH_ALL;
				else if (pick < 97)
					m = MODE_NMI_OVERFLOW;
				else
					m = MODE_UNUSED;

				// half the events crowd onto two cpus so episodes build up
				c = ($urandom_range(0, 1) != 0) ? CPU_W'($urandom_range(0, 1))
					: CPU_W'($urandom_range(0, NCPU - 1));

				// mostly a steadily advancing clock with occasional jumps past the
				// threshold; the rest is an arbitrary clock value
				if ($urandom_range(0, 99) < 80) begin
					sec_base = sec_base + SEC_W'($urandom_range(0, 2));
					if ($urandom_range(0, 99) < 8)
						sec_base = sec_base + SEC_W'($urandom_range(0, 2 * int'(thr) + 2));
					t = {sec_base, 30'($urandom)};
				end else begin
					t = {$urandom, $urandom};
				end

				send_event(m, c, t);
			end
		end

		drain();
		repeat (5) @(posedge clk);
		if (sb.faults == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
